/* rtl/square_matrix_multiply_assert.svh */
// assertion macros for the square matrix multiplier
// included by the top level; no other dependencies
`ifndef SQUARE_MATRIX_MULTIPLY_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SMM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smm assertion failed");
// next-cycle implication
`define SMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smm assertion failed");
`else
`define SMM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SMM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/smm_pkg.sv */
// shared constants, opcodes and types for the square matrix multiplier
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package smm_pkg;
   localparam int MAX_SIZE     = 64;
   localparam int ELEMENT_BITS = 16;
   localparam int INDEX_BITS   = 6;
   localparam int SIZE_BITS    = 7;
   localparam int ADDR_BITS    = $clog2(MAX_SIZE * MAX_SIZE);
   localparam int STORE_DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int PRODUCT_BITS = 2 * ELEMENT_BITS;
   localparam int ACC_BITS     = 38;
   localparam int OPCODE_BITS  = 2;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [OPCODE_BITS-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_QUERY   = 2'd2;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 7'd64;

   // control into the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctrl_type;
endpackage
`default_nettype wire

/* rtl/square_matrix_multiply.sv */
// square matrix multiplier top level: element stores, query sequencer, result register
// depends on smm_pkg, smm_mac and square_matrix_multiply_assert.svh
//
// usage
//   req channel: one word per command; tuser carries the opcode (write A element,
//   write B element, query C element), tdata the indexes and element value.
//   writes finish in the accepting cycle and give no result. a query walks
//   k = 0 .. n-1 through one multiply-accumulate unit: one read of each element
//   store per cycle, read data registered, product registered, then accumulate.
//   a query's word goes to rsp once the pipeline has drained, n being the size capped
//   at 64; with a size of zero the walk is skipped and the word is a zero sum.
//   req_tready is low while a query runs, so a new query is accepted only after the
//   last one has finished.
//   rsp channel: one word per query, held in an output register until taken;
//   loads and a new query are accepted while it waits, and a finishing query
//   waits for the register to free up if the receiver stalls.
//   csr channel: writes the matrix size, always ready; write it only when idle.
//   reset clears the sequencer, the result register and sets the size to 64;
//   element stores are not cleared and must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none
`include "square_matrix_multiply_assert.svh"
module square_matrix_multiply (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // req word
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tdata from bit 0: row_index[5:0], col_index[11:6], element_value[27:12], zero pad
   input  wire logic [smm_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // tuser from bit 0: opcode[1:0]
   input  wire logic [smm_pkg::OPCODE_BITS-1:0]       req_tuser,
   // rsp word
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // tdata from bit 0: product_entry[37:0], zero pad
   output logic [smm_pkg::RSP_DATA_BITS-1:0]          rsp_tdata,
   // size register write
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [smm_pkg::SIZE_BITS-1:0]         csr_data
);
   import smm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [INDEX_BITS-1:0]          req_row, req_col;
   logic signed [ELEMENT_BITS-1:0] req_value;
   logic                           req_accept, req_in_range;
   logic [ADDR_BITS-1:0]           wr_addr, a_addr, b_addr;

   logic [1:0]                     state_ff, state_in;
   logic [SIZE_BITS-1:0]           k_ff, k_in;
   logic [INDEX_BITS-1:0]          row_ff, row_in, col_ff, col_in;
   logic [SIZE_BITS-1:0]           size_ff, size_in, eff_size;
   logic                           rd_valid_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_BITS-1:0]     rsp_data_ff, rsp_data_in;
   logic                           finish;

   logic signed [ELEMENT_BITS-1:0] left_store_mem  [STORE_DEPTH];
   logic signed [ELEMENT_BITS-1:0] right_store_mem [STORE_DEPTH];
   logic signed [ELEMENT_BITS-1:0] a_rd_ff, b_rd_ff;

   mac_ctrl_type                   mac_ctrl;
   logic                           mac_busy;
   logic signed [ACC_BITS-1:0]     mac_acc;

   assign req_row   = req_tdata[INDEX_BITS-1:0];
   assign req_col   = req_tdata[2*INDEX_BITS-1:INDEX_BITS];
   assign req_value = req_tdata[2*INDEX_BITS+ELEMENT_BITS-1:2*INDEX_BITS];

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_in_range = ({1'b0, req_row} < SIZE_BITS'(MAX_SIZE))
                      && ({1'b0, req_col} < SIZE_BITS'(MAX_SIZE));

   assign eff_size = (size_ff > SIZE_BITS'(MAX_SIZE)) ? SIZE_BITS'(MAX_SIZE) : size_ff;

   // row-major addressing
   assign wr_addr = ADDR_BITS'(req_row) * ADDR_BITS'(MAX_SIZE) + ADDR_BITS'(req_col);
   assign a_addr  = ADDR_BITS'(row_ff) * ADDR_BITS'(MAX_SIZE)
                  + ADDR_BITS'(k_ff[INDEX_BITS-1:0]);
   assign b_addr  = ADDR_BITS'(k_ff[INDEX_BITS-1:0]) * ADDR_BITS'(MAX_SIZE)
                  + ADDR_BITS'(col_ff);

   always_ff @(posedge clock) begin
      if (req_accept && req_in_range && (req_tuser == OP_WRITE_A)) begin
         left_store_mem[wr_addr] <= req_value;
      end
      a_rd_ff <= left_store_mem[a_addr];
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_in_range && (req_tuser == OP_WRITE_B)) begin
         right_store_mem[wr_addr] <= req_value;
      end
      b_rd_ff <= right_store_mem[b_addr];
   end

   assign mac_ctrl.clear = req_accept && (req_tuser == OP_QUERY);
   assign mac_ctrl.valid = rd_valid_ff;

   smm_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .a_value (a_rd_ff),
      .b_value (b_rd_ff),
      .busy    (mac_busy),
      .acc     (mac_acc)
   );

   // pipeline empty and the result register free
   assign finish = (state_ff == ST_DRAIN) && !rd_valid_ff && !mac_busy
                && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == OP_QUERY)) begin
               k_in   = '0;
               row_in = req_row;
               col_in = req_col;
               state_in = (req_in_range && (eff_size != '0)) ? ST_RUN : ST_DRAIN;
            end
         end
         ST_RUN: begin
            k_in = k_ff + 1'b1;
            if (k_in >= eff_size) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = mac_acc;
      end
   end

   assign size_in   = (csr_valid && csr_ready) ? csr_data : size_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= (state_ff == ST_RUN);
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-ACC_BITS){1'b0}}, rsp_data_ff};

   `SMM_ASSERT_IMPLIES(a_k_below_size, clock, reset, state_ff == ST_RUN, k_ff < eff_size)
   `SMM_ASSERT_NEXT(a_query_holds_ready, clock, reset,
      req_accept && (req_tuser == OP_QUERY), state_ff != ST_IDLE)
   `SMM_ASSERT_IMPLIES(a_idle_pipe_empty, clock, reset, state_ff == ST_IDLE,
      !rd_valid_ff && !mac_busy)
endmodule
`default_nettype wire

/* rtl/smm_mac.sv */
// shared multiply-accumulate unit: registered product, then wide accumulate
// depends on smm_pkg
`timescale 1ns / 1ps
`default_nettype none
module smm_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire smm_pkg::mac_ctrl_type                ctrl,
   input  wire logic signed [smm_pkg::ELEMENT_BITS-1:0] a_value,
   input  wire logic signed [smm_pkg::ELEMENT_BITS-1:0] b_value,
   output logic                                      busy,
   output logic signed [smm_pkg::ACC_BITS-1:0]       acc
);
   import smm_pkg::*;

   logic signed [PRODUCT_BITS-1:0] product_ff;
   logic                           product_valid_ff;
   logic signed [ACC_BITS-1:0]     acc_ff, acc_in;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (product_valid_ff) begin
         acc_in = acc_ff + ACC_BITS'(product_ff);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= a_value * b_value;
      if (reset) begin
         product_valid_ff <= 1'b0;
         acc_ff           <= '0;
      end else begin
         product_valid_ff <= ctrl.valid;
         acc_ff           <= acc_in;
      end
   end

   assign busy = product_valid_ff;
   assign acc  = acc_ff;
endmodule
`default_nettype wire

/* verif/tb.sv */
// self-checking testbench for the square matrix multiplier: loads A and B elements,
// queries C entries and checks each against a dot product worked out in the bench
// depends on smm_pkg and the square_matrix_multiply rtl
`timescale 1ns / 1ps
module tb;
   import smm_pkg::*;

   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 5000;
   localparam int TAIL_CYCLES = MAX_SIZE + 8;
   localparam int SETTLE_CYCLES = 4;

   localparam logic signed [ELEMENT_BITS-1:0] ELEM_MIN  = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
   localparam logic signed [ELEMENT_BITS-1:0] ELEM_MAX  = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
   localparam logic signed [ELEMENT_BITS-1:0] ELEM_ZERO = '0;
   localparam logic signed [ELEMENT_BITS-1:0] ELEM_ONES = '1;

   // req tdata fields, row_index in the lowest bits
   typedef struct packed {
      logic signed [ELEMENT_BITS-1:0] element_value;
      logic [INDEX_BITS-1:0]          col_index;
      logic [INDEX_BITS-1:0]          row_index;
   } req_fields_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata;
   logic [OPCODE_BITS-1:0]     req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [SIZE_BITS-1:0]       csr_data;

   // bench copy of the element stores and the size register
   logic signed [ELEMENT_BITS-1:0] left_store  [0:STORE_DEPTH-1];
   logic signed [ELEMENT_BITS-1:0] right_store [0:STORE_DEPTH-1];
   bit                             left_known  [0:STORE_DEPTH-1];
   bit                             right_known [0:STORE_DEPTH-1];
   int                             size_setting = 64;

   logic [ACC_BITS-1:0] expected_entries [$];

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int items_sent = 0;
   int writes_sent = 0;
   int queries_sent = 0;
   int size_writes = 0;
   int entries_checked = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   square_matrix_multiply u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int active_size();
      return (size_setting > MAX_SIZE) ? MAX_SIZE : size_setting;
   endfunction

   // dot product of row of A with column of B over the active size
   function automatic logic [ACC_BITS-1:0] predict_entry(input int row, input int col);
      logic signed [ACC_BITS-1:0]       acc;
      logic signed [PRODUCT_BITS-1:0]   prod;
      int                               k;
      acc = '0;
      for (k = 0; k < active_size(); k++) begin
         prod = left_store[row*MAX_SIZE + k] * right_store[k*MAX_SIZE + col];
         acc = acc + {{(ACC_BITS-PRODUCT_BITS){prod[PRODUCT_BITS-1]}}, prod};
      end
      return acc;
   endfunction

   function automatic logic signed [ELEMENT_BITS-1:0] random_element();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0: return ELEM_MIN;
         1: return ELEM_MAX;
         2: return ELEM_ZERO;
         default: return r[ELEMENT_BITS-1:0];
      endcase
   endfunction

   function automatic int pick_index();
      return ($urandom_range(1) == 1) ? $urandom_range(7) : $urandom_range(MAX_SIZE-1);
   endfunction

   function automatic void note_mismatch(input string what, input logic [ACC_BITS-1:0] want,
                                         input logic [ACC_BITS-1:0] got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
   endfunction

   // result checker
   always @(posedge clock) begin : check_rsp
      logic [ACC_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_entries.size() == 0) begin
            note_mismatch("product word with none outstanding", '0, rsp_tdata[ACC_BITS-1:0]);
         end else begin
            want = expected_entries.pop_front();
            entries_checked++;
            if (rsp_tdata[ACC_BITS-1:0] !== want)
               note_mismatch("product_entry", want, rsp_tdata[ACC_BITS-1:0]);
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input logic [OPCODE_BITS-1:0] op, input int row, input int col,
                            input logic signed [ELEMENT_BITS-1:0] value);
      req_fields_type fields;
      int             at;
      fields.row_index     = row[INDEX_BITS-1:0];
      fields.col_index     = col[INDEX_BITS-1:0];
      fields.element_value = value;
      at = row*MAX_SIZE + col;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(fields);
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      case (op)
         OP_WRITE_A: begin
            left_store[at] = value;
            left_known[at] = 1'b1;
            writes_sent++;
         end
         OP_WRITE_B: begin
            right_store[at] = value;
            right_known[at] = 1'b1;
            writes_sent++;
         end
         OP_QUERY: begin
            expected_entries.push_back(predict_entry(row, col));
            queries_sent++;
         end
         default: ;
      endcase
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   // sender holds off until every outstanding product word has come back
   task automatic hold_until_answered();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_entries.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_size(input int value);
      hold_until_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[SIZE_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
      size_setting = value;
      size_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // loads any operand the query would read that is still unwritten, then queries
   task automatic issue_query(input int row, input int col);
      int k;
      for (k = 0; k < active_size(); k++) begin
         if (!left_known[row*MAX_SIZE + k])
            send_word(OP_WRITE_A, row, k, random_element());
         if (!right_known[k*MAX_SIZE + col])
            send_word(OP_WRITE_B, k, col, random_element());
      end
      send_word(OP_QUERY, row, col, random_element());
   endtask

   task automatic test_directed_cases();
      sender_idle_pct = 24;
      receiver_idle_pct = 56;
      write_size(2);
      // most negative operands everywhere gives the largest positive sum
      send_word(OP_WRITE_A, 0, 0, ELEM_MIN);
      send_word(OP_WRITE_A, 0, 1, ELEM_MIN);
      send_word(OP_WRITE_B, 0, 0, ELEM_MIN);
      send_word(OP_WRITE_B, 1, 0, ELEM_MIN);
      issue_query(0, 0);
      // overwrite then query again
      send_word(OP_WRITE_A, 0, 1, ELEM_MAX);
      issue_query(0, 0);
      send_word(OP_WRITE_B, 0, 63, ELEM_MAX);
      send_word(OP_WRITE_B, 1, 63, ELEM_MAX);
      issue_query(0, 63);
      // row and column beyond the active size are stored and computed as usual
      send_word(OP_WRITE_A, 63, 0, ELEM_ZERO);
      send_word(OP_WRITE_A, 63, 1, ELEM_ONES);
      send_word(OP_WRITE_A, 5, 40, 16'sh1234);
      issue_query(63, 63);
      // unused opcode must leave the stores alone and give no word
      send_word(OP_UNUSED, 63, 1, ELEM_MAX);
      send_word(OP_UNUSED, 0, 0, ELEM_MIN);
      issue_query(63, 63);
      // empty sum
      write_size(0);
      issue_query(17, 42);
      send_word(OP_UNUSED, 63, 63, ELEM_ONES);
      issue_query(63, 0);
   endtask

   task automatic test_size_extremes();
      write_size(1);
      issue_query(63, 0);
      issue_query(40, 20);
      write_size(64);
      issue_query(0, 0);
      issue_query(63, 63);
      // sizes above the bound saturate, all operands already loaded
      write_size(127);
      issue_query(0, 0);
      issue_query(0, 63);
      issue_query(63, 0);
      issue_query(63, 63);
      write_size(100);
      issue_query(0, 63);
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                      input int item_target);
      int start;
      int next_resize;
      int pick;
      sender_idle_pct = snd_pct;
      receiver_idle_pct = rcv_pct;
      start = items_sent;
      next_resize = 0;
      while (items_sent - start < item_target) begin
         if (items_sent - start >= next_resize) begin
            write_size(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12));
            next_resize += 50;
         end
         pick = $urandom_range(99);
         if (pick < 8)
            send_word(OP_UNUSED, $urandom_range(63), $urandom_range(63), random_element());
         else if (pick < 50)
            send_word(($urandom_range(1) == 1) ? OP_WRITE_B : OP_WRITE_A,
                      pick_index(), pick_index(), random_element());
         else if (pick < 96)
            issue_query(pick_index(), pick_index());
         else
            hold_until_answered();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_size_extremes();
      test_random_traffic(24, 56, 60);
      test_random_traffic(56, 24, 60);
      test_random_traffic(0, 0, 60);

      hold_until_answered();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d element loads and %0d product queries over %0d size settings",
               writes_sent, queries_sent, size_writes);
      $display("%0d product words checked, %0d mismatches", entries_checked, error_count);
      if (error_count == 0 && expected_entries.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
